[design/ths_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package ths_pkg;

  localparam int FRAC_BITS_DEF = 14;
  localparam int NUM_NODES     = 8;
  localparam int NODE_W        = 3;
  localparam int AXES          = 3;
  localparam int XI_W          = 16;
  localparam int SIGNS_W       = 24;
  localparam int BIT_IDX_W     = 5;
  localparam int OUT_W         = 15;

  localparam logic [SIGNS_W-1:0] SIGNS_RESET = 24'hDEC4C8;
  localparam logic [OUT_W-1:0]   SHAPE_HI    = 15'd16384;
  localparam logic [OUT_W-1:0]   GRAD_HI     = 15'd8192;

  typedef struct packed {
    logic              vld;
    logic [NODE_W-1:0] node;
    logic              last;
  } ctl_t;

  typedef struct packed {
    logic            shape;
    logic [AXES-1:0] grad;
  } sgn_t;

  // magnitude width of one factor (1 +- xi)
  function automatic int fac_mag_w(input int frac);
    fac_mag_w = ((frac > XI_W - 1) ? frac : XI_W - 1) + 2;
  endfunction

endpackage

`default_nettype wire

[design/ths_seq.sv]
`timescale 1ns / 1ps
`default_nettype none

module ths_seq #(
  parameter int FRAC_BITS = ths_pkg::FRAC_BITS_DEF,
  parameter int MW        = ths_pkg::fac_mag_w(FRAC_BITS)
) (
  input  wire logic                                       clk,
  input  wire logic                                       rst_n,
  input  wire logic                                       start,
  output logic                                            busy,
  input  wire logic signed [ths_pkg::XI_W-1:0]            in_xi0,
  input  wire logic signed [ths_pkg::XI_W-1:0]            in_xi1,
  input  wire logic signed [ths_pkg::XI_W-1:0]            in_xi2,
  input  wire logic        [ths_pkg::SIGNS_W-1:0]         signs,
  output logic             [ths_pkg::AXES-1:0][MW-1:0]    s1_mag_r,
  output ths_pkg::ctl_t                                   s1_ctl_r,
  output ths_pkg::sgn_t                                   s1_sgn_r
);

  localparam logic [ths_pkg::NODE_W-1:0] LAST_NODE = ths_pkg::NODE_W'(ths_pkg::NUM_NODES - 1);
  localparam logic signed [MW:0] ONE = (MW+1)'(1) << FRAC_BITS;

  logic                                        act_r, act_nxt;
  logic [ths_pkg::NODE_W-1:0]                  cnt_r, cnt_nxt;
  logic signed [ths_pkg::AXES-1:0][ths_pkg::XI_W-1:0] xi_r;
  logic                                        accept;

  logic [ths_pkg::AXES-1:0][MW-1:0]            mag_nxt;
  logic [ths_pkg::AXES-1:0]                    plus;
  logic [ths_pkg::AXES-1:0]                    neg;
  ths_pkg::sgn_t                               sgn_nxt;
  ths_pkg::ctl_t                               ctl_nxt;

  assign busy   = act_r && (cnt_r != LAST_NODE);
  assign accept = start && !busy;

  always_comb begin
    act_nxt = act_r;
    cnt_nxt = cnt_r;
    if (accept) begin
      act_nxt = 1'b1;
      cnt_nxt = '0;
    end else if (act_r) begin
      if (cnt_r == LAST_NODE) begin
        act_nxt = 1'b0;
      end
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      act_r <= act_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      xi_r[0] <= in_xi0;
      xi_r[1] <= in_xi1;
      xi_r[2] <= in_xi2;
    end
  end

  // factors of the node under issue
  always_comb begin
    logic signed [MW:0]                xe;
    logic signed [MW:0]                fac;
    logic [ths_pkg::BIT_IDX_W-1:0]     bi;
    for (int ax = 0; ax < ths_pkg::AXES; ax++) begin
      bi       = ths_pkg::BIT_IDX_W'(cnt_r) * ths_pkg::BIT_IDX_W'(3)
               + ths_pkg::BIT_IDX_W'(ax);
      plus[ax] = signs[bi];
      xe       = (MW+1)'(signed'(xi_r[ax]));
      fac      = plus[ax] ? (ONE + xe) : (ONE - xe);
      neg[ax]  = fac[MW];
      mag_nxt[ax] = neg[ax] ? MW'(-fac) : MW'(fac);
    end
    sgn_nxt.shape   = neg[0] ^ neg[1] ^ neg[2];
    sgn_nxt.grad[0] = ~plus[0] ^ neg[1] ^ neg[2];
    sgn_nxt.grad[1] = neg[0] ^ ~plus[1] ^ neg[2];
    sgn_nxt.grad[2] = neg[0] ^ neg[1] ^ ~plus[2];
    ctl_nxt.vld     = act_r;
    ctl_nxt.node    = cnt_r;
    ctl_nxt.last    = (cnt_r == LAST_NODE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r.vld <= 1'b0;
    end else begin
      s1_ctl_r.vld <= ctl_nxt.vld;
    end
    s1_ctl_r.node <= ctl_nxt.node;
    s1_ctl_r.last <= ctl_nxt.last;
  end

  always_ff @(posedge clk) begin
    s1_sgn_r      <= sgn_nxt;
    s1_mag_r      <= mag_nxt;
  end

endmodule

`default_nettype wire

[design/ths_mul.sv]
`timescale 1ns / 1ps
`default_nettype none

module ths_mul #(
  parameter int FRAC_BITS = ths_pkg::FRAC_BITS_DEF,
  parameter int MW        = ths_pkg::fac_mag_w(FRAC_BITS)
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic          [ths_pkg::AXES-1:0][MW-1:0]     s1_mag,
  input  wire ths_pkg::ctl_t                                 s1_ctl,
  input  wire ths_pkg::sgn_t                                 s1_sgn,
  output logic               [2*MW-1:0]                      s3_alo_r,
  output logic               [2*MW-1:0]                      s3_ahi_r,
  output logic               [ths_pkg::AXES-1:0][ths_pkg::OUT_W-1:0] s3_grad_r,
  output ths_pkg::ctl_t                                      s3_ctl_r,
  output logic                                               s3_neg_r
);

  localparam int PW = 2 * MW;
  localparam logic [PW:0] GHALF = (PW+1)'(1) << (FRAC_BITS + 2);

  // stage 2: pairwise products, entry a is the product that leaves out axis a
  logic [ths_pkg::AXES-1:0][PW-1:0] p2_r;
  logic [MW-1:0]                    m2_r;
  ths_pkg::ctl_t                    ctl2_r;
  ths_pkg::sgn_t                    sgn2_r;

  logic [ths_pkg::AXES-1:0][ths_pkg::OUT_W-1:0] grad_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl2_r.vld   <= 1'b0;
      s3_ctl_r.vld <= 1'b0;
    end else begin
      ctl2_r.vld   <= s1_ctl.vld;
      s3_ctl_r.vld <= ctl2_r.vld;
    end
    ctl2_r.node   <= s1_ctl.node;
    ctl2_r.last   <= s1_ctl.last;
    s3_ctl_r.node <= ctl2_r.node;
    s3_ctl_r.last <= ctl2_r.last;
  end

  always_ff @(posedge clk) begin
    p2_r[0]      <= PW'(s1_mag[1]) * PW'(s1_mag[2]);
    p2_r[1]      <= PW'(s1_mag[0]) * PW'(s1_mag[2]);
    p2_r[2]      <= PW'(s1_mag[0]) * PW'(s1_mag[1]);
    m2_r         <= s1_mag[2];
    sgn2_r       <= s1_sgn;
  end

  // derivatives: round the pair product, clamp, apply sign
  always_comb begin
    logic [PW:0]                 gs;
    logic [PW:0]                 gq;
    logic [ths_pkg::OUT_W-1:0]   gm;
    for (int ax = 0; ax < ths_pkg::AXES; ax++) begin
      gs = {1'b0, p2_r[ax]} + GHALF;
      gq = gs >> (FRAC_BITS + 3);
      gm = (gq > (PW+1)'(ths_pkg::GRAD_HI)) ? ths_pkg::GRAD_HI : gq[ths_pkg::OUT_W-1:0];
      grad_nxt[ax] = sgn2_r.grad[ax] ? (ths_pkg::OUT_W'(0) - gm) : gm;
    end
  end

  // stage 3: shape product split in two halves
  always_ff @(posedge clk) begin
    s3_alo_r      <= PW'(p2_r[2][MW-1:0]) * PW'(m2_r);
    s3_ahi_r      <= PW'(p2_r[2][PW-1:MW]) * PW'(m2_r);
    s3_grad_r     <= grad_nxt;
    s3_neg_r      <= sgn2_r.shape;
  end

endmodule

`default_nettype wire

[design/ths_fin.sv]
`timescale 1ns / 1ps
`default_nettype none

module ths_fin #(
  parameter int FRAC_BITS = ths_pkg::FRAC_BITS_DEF,
  parameter int MW        = ths_pkg::fac_mag_w(FRAC_BITS)
) (
  input  wire logic                                              clk,
  input  wire logic                                              rst_n,
  input  wire logic          [2*MW-1:0]                          s3_alo,
  input  wire logic          [2*MW-1:0]                          s3_ahi,
  input  wire logic          [ths_pkg::AXES-1:0][ths_pkg::OUT_W-1:0] s3_grad,
  input  wire ths_pkg::ctl_t                                     s3_ctl,
  input  wire logic                                              s3_neg,
  output logic                                                   out_valid,
  output logic               [ths_pkg::NODE_W-1:0]               out_node_index,
  output logic               [ths_pkg::OUT_W-1:0]                out_shape_value,
  output logic signed        [ths_pkg::OUT_W-1:0]                out_grad_xi0,
  output logic signed        [ths_pkg::OUT_W-1:0]                out_grad_xi1,
  output logic signed        [ths_pkg::OUT_W-1:0]                out_grad_xi2,
  output logic                                                   out_last
);

  localparam int SW = 3 * MW + 1;
  localparam logic [SW-1:0] SHALF = SW'(1) << (2 * FRAC_BITS + 2);

  logic                        vld_r;
  logic [SW-1:0]               ssum;
  logic [SW-1:0]               sq;
  logic [ths_pkg::OUT_W-1:0]   shape_nxt;

  always_comb begin
    ssum = (SW'(s3_ahi) << MW) + SW'(s3_alo) + SHALF;
    sq   = ssum >> (2 * FRAC_BITS + 3);
    if (s3_neg) begin
      shape_nxt = '0;
    end else if (sq > SW'(ths_pkg::SHAPE_HI)) begin
      shape_nxt = ths_pkg::SHAPE_HI;
    end else begin
      shape_nxt = sq[ths_pkg::OUT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= s3_ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    out_node_index  <= s3_ctl.node;
    out_last        <= s3_ctl.last;
    out_shape_value <= shape_nxt;
    out_grad_xi0    <= s3_grad[0];
    out_grad_xi1    <= s3_grad[1];
    out_grad_xi2    <= s3_grad[2];
  end

  assign out_valid = vld_r;

endmodule

`default_nettype wire

[design/trilinear_hex_shape_eval.sv]
`timescale 1ns / 1ps
`default_nettype none

// Eight-node trilinear hexahedron shape functions. A point (in_xi0..2, Q2.14) is
// taken when start is high and busy is low; the block then sends eight words, one
// per clock, for nodes 0 to 7, each marked by out_valid for a single cycle and
// out_last on node 7. The node sequencer issues one node a clock into a
// four-stage multiply pipeline; busy drops on the eighth node so points follow each
// other with no gap. The first word of a point passes through the stage-1, stage-2,
// stage-3 and output registers. There is no back-pressure: words must be
// taken as they come. cfg_corner_signs sets the node corner signs and should be
// written only while no point is in flight.
module trilinear_hex_shape_eval #(
  parameter int FRAC_BITS = ths_pkg::FRAC_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   start,
  output logic                                        busy,
  input  wire logic signed [ths_pkg::XI_W-1:0]        in_xi0,
  input  wire logic signed [ths_pkg::XI_W-1:0]        in_xi1,
  input  wire logic signed [ths_pkg::XI_W-1:0]        in_xi2,
  output logic                                        out_valid,
  output logic             [ths_pkg::NODE_W-1:0]      out_node_index,
  output logic             [ths_pkg::OUT_W-1:0]       out_shape_value,
  output logic signed      [ths_pkg::OUT_W-1:0]       out_grad_xi0,
  output logic signed      [ths_pkg::OUT_W-1:0]       out_grad_xi1,
  output logic signed      [ths_pkg::OUT_W-1:0]       out_grad_xi2,
  output logic                                        out_last,
  input  wire logic                                   cfg_valid,
  output logic                                        cfg_ready,
  input  wire logic        [ths_pkg::SIGNS_W-1:0]     cfg_corner_signs
);

  localparam int MW = ths_pkg::fac_mag_w(FRAC_BITS);

  logic [ths_pkg::SIGNS_W-1:0]                         signs_r;
  logic [ths_pkg::AXES-1:0][MW-1:0]                    s1_mag;
  ths_pkg::ctl_t                                       s1_ctl;
  ths_pkg::sgn_t                                       s1_sgn;
  logic [2*MW-1:0]                                     s3_alo;
  logic [2*MW-1:0]                                     s3_ahi;
  logic [ths_pkg::AXES-1:0][ths_pkg::OUT_W-1:0]        s3_grad;
  ths_pkg::ctl_t                                       s3_ctl;
  logic                                                s3_neg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      signs_r <= ths_pkg::SIGNS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      signs_r <= cfg_corner_signs;
    end
  end

  ths_seq #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_xi0   (in_xi0),
    .in_xi1   (in_xi1),
    .in_xi2   (in_xi2),
    .signs    (signs_r),
    .s1_mag_r (s1_mag),
    .s1_ctl_r (s1_ctl),
    .s1_sgn_r (s1_sgn)
  );

  ths_mul #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW)
  ) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .s1_mag    (s1_mag),
    .s1_ctl    (s1_ctl),
    .s1_sgn    (s1_sgn),
    .s3_alo_r  (s3_alo),
    .s3_ahi_r  (s3_ahi),
    .s3_grad_r (s3_grad),
    .s3_ctl_r  (s3_ctl),
    .s3_neg_r  (s3_neg)
  );

  ths_fin #(
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW)
  ) u_fin (
    .clk             (clk),
    .rst_n           (rst_n),
    .s3_alo          (s3_alo),
    .s3_ahi          (s3_ahi),
    .s3_grad         (s3_grad),
    .s3_ctl          (s3_ctl),
    .s3_neg          (s3_neg),
    .out_valid       (out_valid),
    .out_node_index  (out_node_index),
    .out_shape_value (out_shape_value),
    .out_grad_xi0    (out_grad_xi0),
    .out_grad_xi1    (out_grad_xi1),
    .out_grad_xi2    (out_grad_xi2),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

[test/shape_checker.sv]
`timescale 1ns / 1ps

module shape_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic                              busy,
  input  logic signed [ths_pkg::XI_W-1:0]   in_xi0,
  input  logic signed [ths_pkg::XI_W-1:0]   in_xi1,
  input  logic signed [ths_pkg::XI_W-1:0]   in_xi2,
  input  logic                              out_valid,
  input  logic [ths_pkg::NODE_W-1:0]        out_node_index,
  input  logic [ths_pkg::OUT_W-1:0]         out_shape_value,
  input  logic [ths_pkg::OUT_W-1:0]         out_grad_xi0,
  input  logic [ths_pkg::OUT_W-1:0]         out_grad_xi1,
  input  logic [ths_pkg::OUT_W-1:0]         out_grad_xi2,
  input  logic                              out_last,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [ths_pkg::SIGNS_W-1:0]       cfg_corner_signs,
  output int                                mismatches,
  output int                                pending
);

  typedef struct packed {
    logic [ths_pkg::NODE_W-1:0] node;
    logic [ths_pkg::OUT_W-1:0]  shape;
    logic [ths_pkg::OUT_W-1:0]  grad0;
    logic [ths_pkg::OUT_W-1:0]  grad1;
    logic [ths_pkg::OUT_W-1:0]  grad2;
    logic                       last;
  } node_word_t;

  localparam int PROD_SHIFT = 2 * ths_pkg::FRAC_BITS_DEF + 3;

  node_word_t                  node_words_due[$];
  logic [ths_pkg::SIGNS_W-1:0] corner_signs_q;
  int                          fail_count;

  // exact triple product, divided by 8 and the format, nearest with ties away from zero
  function automatic longint round_product(input longint a, input longint b, input longint c,
                                           input longint lo, input longint hi);
    longint p;
    longint m;
    longint q;
    p = a * b * c;
    m = (p < 0) ? -p : p;
    q = (m + (longint'(1) << (PROD_SHIFT - 1))) >>> PROD_SHIFT;
    if (p < 0) q = -q;
    if (q < lo) q = lo;
    if (q > hi) q = hi;
    return q;
  endfunction

  function automatic node_word_t predict_node(input logic [ths_pkg::SIGNS_W-1:0] signs,
                                              input logic signed [ths_pkg::XI_W-1:0] x0,
                                              input logic signed [ths_pkg::XI_W-1:0] x1,
                                              input logic signed [ths_pkg::XI_W-1:0] x2,
                                              input int node);
    longint     one;
    longint     xv  [ths_pkg::AXES];
    longint     fac [ths_pkg::AXES];
    longint     sgn [ths_pkg::AXES];
    longint     glo;
    longint     ghi;
    node_word_t w;
    one = longint'(1) << ths_pkg::FRAC_BITS_DEF;
    xv[0] = x0;
    xv[1] = x1;
    xv[2] = x2;
    for (int ax = 0; ax < ths_pkg::AXES; ax++) begin
      if (signs[ths_pkg::AXES * node + ax]) begin
        sgn[ax] = one;
        fac[ax] = one + xv[ax];
      end else begin
        sgn[ax] = -one;
        fac[ax] = one - xv[ax];
      end
    end
    ghi = longint'(ths_pkg::GRAD_HI);
    glo = -ghi;
    w.node  = ths_pkg::NODE_W'(node);
    w.shape = ths_pkg::OUT_W'(round_product(fac[0], fac[1], fac[2], 0,
                                            longint'(ths_pkg::SHAPE_HI)));
    w.grad0 = ths_pkg::OUT_W'(round_product(sgn[0], fac[1], fac[2], glo, ghi));
    w.grad1 = ths_pkg::OUT_W'(round_product(fac[0], sgn[1], fac[2], glo, ghi));
    w.grad2 = ths_pkg::OUT_W'(round_product(fac[0], fac[1], sgn[2], glo, ghi));
    w.last  = (node == ths_pkg::NUM_NODES - 1);
    return w;
  endfunction

  always @(posedge clk) begin : watch
    node_word_t got;
    node_word_t want;
    if (!rst_n) begin
      corner_signs_q = ths_pkg::SIGNS_RESET;
      node_words_due.delete();
    end else begin
      if (out_valid) begin
        got = '{out_node_index, out_shape_value, out_grad_xi0, out_grad_xi1, out_grad_xi2,
                out_last};
        if (node_words_due.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: node %0d shape %0d grads %0d %0d %0d last %0d",
                     got.node, got.shape, $signed(got.grad0), $signed(got.grad1),
                     $signed(got.grad2), got.last);
        end else begin
          want = node_words_due.pop_front();
          if (got.node !== want.node || got.shape !== want.shape ||
              got.grad0 !== want.grad0 || got.grad1 !== want.grad1 ||
              got.grad2 !== want.grad2 || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"word mismatch: expected node %0d shape %0d grads %0d %0d %0d ",
                        "last %0d, got node %0d shape %0d grads %0d %0d %0d last %0d"},
                       want.node, want.shape, $signed(want.grad0), $signed(want.grad1),
                       $signed(want.grad2), want.last, got.node, got.shape,
                       $signed(got.grad0), $signed(got.grad1), $signed(got.grad2),
                       got.last);
          end
        end
      end
      if (start && !busy) begin
        for (int n = 0; n < ths_pkg::NUM_NODES; n++)
          node_words_due.push_back(predict_node(corner_signs_q, in_xi0, in_xi1, in_xi2, n));
      end
      if (cfg_valid && cfg_ready) corner_signs_q = cfg_corner_signs;
    end
    mismatches <= fail_count;
    pending    <= node_words_due.size();
  end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  logic                            clk;
  logic                            rst_n;
  logic                            start;
  logic                            busy;
  logic signed [ths_pkg::XI_W-1:0] in_xi0;
  logic signed [ths_pkg::XI_W-1:0] in_xi1;
  logic signed [ths_pkg::XI_W-1:0] in_xi2;
  logic                            out_valid;
  logic [ths_pkg::NODE_W-1:0]      out_node_index;
  logic [ths_pkg::OUT_W-1:0]       out_shape_value;
  logic [ths_pkg::OUT_W-1:0]       out_grad_xi0;
  logic [ths_pkg::OUT_W-1:0]       out_grad_xi1;
  logic [ths_pkg::OUT_W-1:0]       out_grad_xi2;
  logic                            out_last;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [ths_pkg::SIGNS_W-1:0]     cfg_corner_signs;
  int                              mismatches;
  int                              pending;

  int                              idle_pct;
  int                              phase_idle [6];
  logic [ths_pkg::SIGNS_W-1:0]     phase_signs [6];

  trilinear_hex_shape_eval dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_xi0           (in_xi0),
    .in_xi1           (in_xi1),
    .in_xi2           (in_xi2),
    .out_valid        (out_valid),
    .out_node_index   (out_node_index),
    .out_shape_value  (out_shape_value),
    .out_grad_xi0     (out_grad_xi0),
    .out_grad_xi1     (out_grad_xi1),
    .out_grad_xi2     (out_grad_xi2),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_corner_signs (cfg_corner_signs)
  );

  shape_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_xi0           (in_xi0),
    .in_xi1           (in_xi1),
    .in_xi2           (in_xi2),
    .out_valid        (out_valid),
    .out_node_index   (out_node_index),
    .out_shape_value  (out_shape_value),
    .out_grad_xi0     (out_grad_xi0),
    .out_grad_xi1     (out_grad_xi1),
    .out_grad_xi2     (out_grad_xi2),
    .out_last         (out_last),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_corner_signs (cfg_corner_signs),
    .mismatches       (mismatches),
    .pending          (pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #2000000;
    $display("status: fail");
    $finish;
  end

  // mostly inside the element, the rest anywhere in the 16-bit range
  function automatic logic signed [ths_pkg::XI_W-1:0] pick_coord();
    if ($urandom_range(99) < 80)
      return ths_pkg::XI_W'(int'($urandom_range(32768)) - 16384);
    return ths_pkg::XI_W'($urandom);
  endfunction

  task automatic send_point(input logic signed [ths_pkg::XI_W-1:0] x0,
                            input logic signed [ths_pkg::XI_W-1:0] x1,
                            input logic signed [ths_pkg::XI_W-1:0] x2);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start  <= 1'b1;
    in_xi0 <= x0;
    in_xi1 <= x1;
    in_xi2 <= x2;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  // drain every word of the phase, then let the pipeline empty
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_signs(input logic [ths_pkg::SIGNS_W-1:0] value);
    cfg_valid        <= 1'b1;
    cfg_corner_signs <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    rst_n            = 1'b0;
    start            = 1'b0;
    in_xi0           = '0;
    in_xi1           = '0;
    in_xi2           = '0;
    cfg_valid        = 1'b0;
    cfg_corner_signs = '0;
    idle_pct         = 0;
    phase_idle  = '{0, 71, 0, 36, 71, 0};
    phase_signs = '{24'h000000, 24'hFFFFFF, ths_pkg::SIGNS_RESET, 24'h0, 24'h0, 24'h0};
    for (int p = 3; p < 6; p++) phase_signs[p] = ths_pkg::SIGNS_W'($urandom);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corners, centre, rounding ties and points outside the element
    send_point(0, 0, 0);
    send_point(16384, 16384, 16384);
    send_point(-16384, -16384, -16384);
    send_point(16384, -16384, 0);
    send_point(-16384, 16384, 16384);
    send_point(1, -1, 1);
    send_point(-1, -1, -1);
    send_point(0, 16384, 2);
    send_point(-2, -16384, 0);
    send_point(16384, 2, -2);
    send_point(8192, -8192, 4096);
    send_point(16383, 0, -16383);
    send_point(16385, -16385, 0);
    send_point(32767, 32767, 32767);
    send_point(-32768, -32768, -32768);
    send_point(32767, -32768, 0);
    send_point(-32768, 32767, 16384);
    send_point(0, 0, 32767);
    send_point(-32768, 0, 0);
    send_point(20000, -5000, 12345);
    drain();

    for (int p = 0; p < 6; p++) begin
      write_signs(phase_signs[p]);
      idle_pct = phase_idle[p];
      for (int i = 0; i < 68; i++) send_point(pick_coord(), pick_coord(), pick_coord());
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
design/ths_pkg.sv
design/ths_seq.sv
design/ths_mul.sv
design/ths_fin.sv
design/trilinear_hex_shape_eval.sv
test/shape_checker.sv
test/testbench.sv
